FILE: hdl/kcec_pkg.sv
// shared types and constants of the point cloud edge classifier
package kcec_pkg;

    // item command codes
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

    localparam int NCOUNT_W = 7;
    localparam int THR_W    = 23;
    localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd50;
    localparam logic [THR_W-1:0]    THR_RESET    = 23'd256;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QRD,
        ST_QLD,
        ST_SCAN,
        ST_SUM,
        ST_MULN,
        ST_DIFF,
        ST_SQ,
        ST_ADD,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/knn_centroid_edge_classifier_top.sv
// top level of the point cloud edge classifier: sequencer, scan pipeline, centroid test
//
// Clear and append complete at the start edge and leave busy low. A classify
// keeps busy high from the start edge through the cycle of the result strobe.
// For a valid index, busy covers one read of the query point, a scan that
// reads every stored point once through the single read port of the point
// ram (one point a cycle, four pipeline stages), a drain of the neighbor list
// that rereads each neighbor for the centroid sum, and a chain of the states
// MULN, DIFF, SQ, ADD and CMP for the offset and threshold squares. An invalid
// index gives its result in the cycle right after the start edge. The result
// appears for one cycle with o_strobe and cannot be held off by the receiver.
// Config writes are always ready.
module knn_centroid_edge_classifier_top
    import kcec_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 64,
    parameter int COORD_BITS    = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [CMD_W-1:0]                      i_command,
    input  logic [$clog2(MAX_POINTS)-1:0]         i_point_index,
    input  logic signed [COORD_BITS-1:0]          i_coord_x,
    input  logic signed [COORD_BITS-1:0]          i_coord_y,
    input  logic signed [COORD_BITS-1:0]          i_coord_z,
    output logic                                  o_strobe,
    output logic [$clog2(MAX_POINTS)-1:0]         o_result_index,
    output logic                                  o_is_edge,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]    o_neighbors_used,
    output logic                                  o_index_valid,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data
);

    localparam int CW   = COORD_BITS;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int SCW  = $clog2(MAX_POINTS + 1);
    localparam int NW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int DW   = CW + 1;
    localparam int DSW  = 2 * DW + 2;
    localparam int SW   = CW + NW;
    localparam int OW   = SW + 1;
    localparam int OSW  = 2 * OW + 2;
    localparam int LW   = NW + THR_W;
    localparam int LSW  = 2 * LW;
    localparam int CMPW = (OSW > LSW) ? OSW : LSW;

    t_state r_state, n_state;

    // configuration
    logic [NCOUNT_W-1:0] r_ncount;
    logic [THR_W-1:0]    r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncount <= NCOUNT_RESET;
            r_thr    <= THR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NEIGHBORS: r_ncount <= i_cfg_data[NCOUNT_W-1:0];
                REG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic accept;
    assign accept = i_start && (r_state == ST_IDLE);

    // control registers
    logic [SCW-1:0] r_stored;
    logic [SCW-1:0] r_cnt;
    logic [NW-1:0]  r_scnt;
    logic [NW-1:0]  r_k;
    logic           r_v0, r_v1, r_v2, r_v3, r_av;
    logic           r_valid;

    // payload registers
    logic [IW-1:0]          r_idx;
    logic signed [CW-1:0]   r_qx, r_qy, r_qz;
    logic [IW-1:0]          r_i0, r_i1, r_i2, r_i3;
    logic [DW-1:0]          r_dx, r_dy, r_dz;
    logic [2*DW-1:0]        r_sx2, r_sy2, r_sz2;
    logic [DSW-1:0]         r_d3;
    logic signed [SW-1:0]   r_accx, r_accy, r_accz;
    logic signed [SW-1:0]   r_npx, r_npy, r_npz;
    logic [OW-1:0]          r_ox, r_oy, r_oz;
    logic [LW-1:0]          r_lt;
    logic [2*OW-1:0]        r_ox2, r_oy2, r_oz2;
    logic [LSW-1:0]         r_lim;
    logic [OSW-1:0]         r_off;
    logic                   r_edge;

    // ram and neighbor list wiring
    logic                   ram_we;
    logic [IW-1:0]          ram_raddr;
    logic [3*CW-1:0]        ram_rdata;
    logic signed [CW-1:0]   mx, my, mz;
    logic                   best_clr, best_shift;
    logic [NW-1:0]          best_len;
    logic [IW-1:0]          best_head;
    logic                   scan_issue, sum_issue, scan_end, sum_end;

    assign mx = ram_rdata[CW-1:0];
    assign my = ram_rdata[2*CW-1:CW];
    assign mz = ram_rdata[3*CW-1:2*CW];

    kcec_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_stored[IW-1:0]),
        .i_wdata ({i_coord_z, i_coord_y, i_coord_x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kcec_best #(
        .DEPTH (MAX_NEIGHBORS),
        .DISTW (DSW),
        .IW    (IW)
    ) u_best (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (best_clr),
        .i_ins      (r_v3),
        .i_dist     (r_d3),
        .i_idx      (r_i3),
        .i_k        (r_k),
        .i_shift    (best_shift),
        .o_len      (best_len),
        .o_head_idx (best_head)
    );

    assign scan_issue = (r_state == ST_SCAN) && (r_cnt < r_stored);
    assign scan_end   = !scan_issue && !r_v0 && !r_v1 && !r_v2 && !r_v3;
    assign sum_issue  = (r_state == ST_SUM) && (r_scnt < best_len);
    assign sum_end    = !sum_issue && !r_av;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_CLASSIFY)) begin
                    n_state = (SCW'(i_point_index) < r_stored) ? ST_QRD : ST_DONE;
                end
            end
            ST_QRD:  n_state = ST_QLD;
            ST_QLD:  n_state = ST_SCAN;
            ST_SCAN: if (scan_end) n_state = ST_SUM;
            ST_SUM:  if (sum_end) n_state = ST_MULN;
            ST_MULN: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_SQ;
            ST_SQ:   n_state = ST_ADD;
            ST_ADD:  n_state = ST_CMP;
            ST_CMP:  n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        ram_we     = 1'b0;
        ram_raddr  = r_cnt[IW-1:0];
        best_clr   = 1'b0;
        best_shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                ram_we = accept && (i_command == CMD_APPEND)
                         && (r_stored < SCW'(MAX_POINTS));
            end
            ST_QRD: begin
                ram_raddr = r_idx;
                best_clr  = 1'b1;
            end
            ST_SUM: begin
                ram_raddr  = best_head;
                best_shift = sum_issue;
            end
            default: ;
        endcase
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_strobe         = (r_state == ST_DONE);
    assign o_result_index   = r_idx;
    assign o_is_edge        = r_valid && r_edge;
    assign o_neighbors_used = r_valid ? best_len : '0;
    assign o_index_valid    = r_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stored <= '0;
            r_cnt    <= '0;
            r_scnt   <= '0;
            r_k      <= NW'(1);
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_av     <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (i_command)
                    CMD_CLEAR:  r_stored <= '0;
                    CMD_APPEND: if (ram_we) r_stored <= r_stored + SCW'(1);
                    CMD_CLASSIFY: begin
                        r_valid <= SCW'(i_point_index) < r_stored;
                        r_cnt   <= '0;
                        r_scnt  <= '0;
                        if (r_ncount == '0) begin
                            r_k <= NW'(1);
                        end else if (int'(r_ncount) > MAX_NEIGHBORS) begin
                            r_k <= NW'(MAX_NEIGHBORS);
                        end else begin
                            r_k <= NW'(r_ncount);
                        end
                    end
                    default: ;
                endcase
            end
            // scan pipeline valids
            r_v0 <= scan_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (scan_issue) begin
                r_cnt <= r_cnt + SCW'(1);
            end
            // centroid drain
            r_av <= sum_issue;
            if (sum_issue) begin
                r_scnt <= r_scnt + NW'(1);
            end
        end
    end

    // datapath
    logic signed [DW-1:0] ddx, ddy, ddz;
    logic signed [OW-1:0] dox, doy, doz;
    logic signed [SW-1:0] nlen;

    always_comb begin
        ddx  = DW'(mx) - DW'(r_qx);
        ddy  = DW'(my) - DW'(r_qy);
        ddz  = DW'(mz) - DW'(r_qz);
        dox  = OW'(r_npx) - OW'(r_accx);
        doy  = OW'(r_npy) - OW'(r_accy);
        doz  = OW'(r_npz) - OW'(r_accz);
        nlen = SW'($signed({1'b0, best_len}));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= i_point_index;
        end
        if (r_state == ST_QLD) begin
            r_qx <= mx;
            r_qy <= my;
            r_qz <= mz;
        end
        // scan stage 0 index, stage 1 differences, stage 2 squares, stage 3 sum
        r_i0  <= r_cnt[IW-1:0];
        r_i1  <= r_i0;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_dx  <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
        r_dy  <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
        r_dz  <= ddz[DW-1] ? DW'(-ddz) : DW'(ddz);
        r_sx2 <= r_dx * r_dx;
        r_sy2 <= r_dy * r_dy;
        r_sz2 <= r_dz * r_dz;
        r_d3  <= DSW'(r_sx2) + DSW'(r_sy2) + DSW'(r_sz2);
        // neighbor coordinate sums
        if (r_state == ST_SCAN) begin
            r_accx <= '0;
            r_accy <= '0;
            r_accz <= '0;
        end else if (r_av) begin
            r_accx <= r_accx + SW'(mx);
            r_accy <= r_accy + SW'(my);
            r_accz <= r_accz + SW'(mz);
        end
        // offset of n times the query point from the sum
        if (r_state == ST_MULN) begin
            r_npx <= nlen * SW'(r_qx);
            r_npy <= nlen * SW'(r_qy);
            r_npz <= nlen * SW'(r_qz);
            r_lt  <= LW'(best_len) * LW'(r_thr);
        end
        if (r_state == ST_DIFF) begin
            r_ox <= dox[OW-1] ? OW'(-dox) : OW'(dox);
            r_oy <= doy[OW-1] ? OW'(-doy) : OW'(doy);
            r_oz <= doz[OW-1] ? OW'(-doz) : OW'(doz);
        end
        if (r_state == ST_SQ) begin
            r_ox2 <= r_ox * r_ox;
            r_oy2 <= r_oy * r_oy;
            r_oz2 <= r_oz * r_oz;
            r_lim <= r_lt * r_lt;
        end
        if (r_state == ST_ADD) begin
            r_off <= OSW'(r_ox2) + OSW'(r_oy2) + OSW'(r_oz2);
        end
        if (r_state == ST_CMP) begin
            r_edge <= CMPW'(r_off) > CMPW'(r_lim);
        end
    end

endmodule

FILE: hdl/kcec_ram.sv
// generic single port write, single port registered read ram
module kcec_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/kcec_best.sv
// sorted list of the k nearest distances with their point indexes
module kcec_best #(
    parameter int DEPTH = 64,
    parameter int DISTW = 52,
    parameter int IW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic                       i_ins,
    input  logic [DISTW-1:0]           i_dist,
    input  logic [IW-1:0]              i_idx,
    input  logic [$clog2(DEPTH+1)-1:0] i_k,
    input  logic                       i_shift,
    output logic [$clog2(DEPTH+1)-1:0] o_len,
    output logic [IW-1:0]              o_head_idx
);

    localparam int NW = $clog2(DEPTH + 1);

    logic [DISTW-1:0] r_best [DEPTH];
    logic [IW-1:0]    r_sel  [DEPTH];
    logic [NW-1:0]    r_len;
    logic [DEPTH-1:0] g;
    logic [DEPTH-1:0] act;
    logic             hit;

    // slot holds something greater than the new distance, or is empty
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            g[j]   = (NW'(j) >= r_len) || (r_best[j] > i_dist);
            act[j] = NW'(j) < i_k;
        end
        hit = |(g & act);
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_clr) begin
            r_len <= '0;
        end else if (i_ins && hit && (r_len < i_k)) begin
            r_len <= r_len + NW'(1);
        end
    end

    // insertion shifts larger entries down, drain shifts indexes up
    for (genvar j = 0; j < DEPTH; j++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (i_ins) begin
                if (act[j] && g[j]) begin
                    if (j == 0) begin
                        r_best[j] <= i_dist;
                        r_sel[j]  <= i_idx;
                    end else if (!g[(j == 0) ? 0 : j-1]) begin
                        r_best[j] <= i_dist;
                        r_sel[j]  <= i_idx;
                    end else begin
                        r_best[j] <= r_best[(j == 0) ? 0 : j-1];
                        r_sel[j]  <= r_sel[(j == 0) ? 0 : j-1];
                    end
                end
            end else if (i_shift && (j < DEPTH-1)) begin
                r_sel[j] <= r_sel[(j < DEPTH-1) ? j+1 : j];
            end
        end
    end

    assign o_len      = r_len;
    assign o_head_idx = r_sel[0];

endmodule
